FILE: hw/rtl/iem_pkg.sv
package iem_pkg;

   // request types
   localparam logic [2:0] REQ_EXEC     = 3'd0;
   localparam logic [2:0] REQ_SET_PAIR = 3'd1;
   localparam logic [2:0] REQ_WR_MEM   = 3'd2;
   localparam logic [2:0] REQ_RD_PAIR  = 3'd3;
   localparam logic [2:0] REQ_RD_MEM   = 3'd4;

   // opcode pages
   localparam logic [1:0] PAGE_ED = 2'd0;
   localparam logic [1:0] PAGE_DD = 2'd1;
   localparam logic [1:0] PAGE_FD = 2'd2;

   // register pair indexes
   localparam logic [2:0] PAIR_BC = 3'd0;
   localparam logic [2:0] PAIR_DE = 3'd1;
   localparam logic [2:0] PAIR_HL = 3'd2;
   localparam logic [2:0] PAIR_IX = 3'd3;
   localparam logic [2:0] PAIR_IY = 3'd4;
   localparam logic [2:0] PAIR_SP = 3'd5;
   localparam int         PAIR_COUNT = 6;

   // second opcode bytes
   localparam logic [7:0] OP_LEA_BC_IX  = 8'h02;
   localparam logic [7:0] OP_LEA_DE_IX  = 8'h12;
   localparam logic [7:0] OP_LEA_HL_IX  = 8'h22;
   localparam logic [7:0] OP_LEA_BC_IY  = 8'h03;
   localparam logic [7:0] OP_LEA_DE_IY  = 8'h13;
   localparam logic [7:0] OP_LEA_HL_IY  = 8'h23;
   localparam logic [7:0] OP_LD_BC_MEM  = 8'h07;
   localparam logic [7:0] OP_LD_DE_MEM  = 8'h17;
   localparam logic [7:0] OP_LD_HL_MEM  = 8'h27;
   localparam logic [7:0] OP_ST_BC_MEM  = 8'h0f;
   localparam logic [7:0] OP_ST_DE_MEM  = 8'h1f;
   localparam logic [7:0] OP_ST_HL_MEM  = 8'h2f;
   localparam logic [7:0] OP_LEA_IX_IX  = 8'h32;
   localparam logic [7:0] OP_LEA_IY_IX  = 8'h55;
   localparam logic [7:0] OP_LEA_IX_IY  = 8'h54;
   localparam logic [7:0] OP_LEA_IY_IY  = 8'h33;
   localparam logic [7:0] OP_PEA_IX     = 8'h65;
   localparam logic [7:0] OP_PEA_IY     = 8'h66;
   localparam logic [7:0] OP_LD_SAME    = 8'h37;
   localparam logic [7:0] OP_LD_OTHER   = 8'h31;
   localparam logic [7:0] OP_ST_SAME    = 8'h3f;
   localparam logic [7:0] OP_ST_OTHER   = 8'h3e;

   // tick counts
   localparam logic [2:0] TICKS_LEA   = 3'd3;
   localparam logic [2:0] TICKS_MOVE  = 3'd4;
   localparam logic [2:0] TICKS_LONG  = 3'd5;
   localparam logic [2:0] TICKS_NONE  = 3'd0;

   localparam int MEM_ADDR_BITS_DEF = 16;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   typedef enum logic [3:0] {
      K_REFUSE,
      K_LEA,
      K_LOAD,
      K_STORE,
      K_PEA,
      K_SET,
      K_RDPAIR,
      K_MEMWR,
      K_RDMEM
   } iem_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_LD1,
      BK_LD2,
      BK_ST2,
      BK_RDM,
      BK_FIN
   } iem_bk_state_type;

   typedef struct packed {
      iem_kind_type kind;
      logic [2:0]   base_idx;
      logic         use_d;
      logic [2:0]   src_idx;
      logic [2:0]   dst_idx;
      logic [2:0]   cycles;
      logic [7:0]   disp;
      logic [15:0]  value;
      logic [15:0]  maddr;
   } iem_uop_type;

endpackage

FILE: hw/rtl/ez80_indexed_move_execute.sv
// Each transaction taken from the queue passes through EXEC and then FIN, with LD1 and
// LD2 between them for loads, ST2 for stores and PEA and RDM for memory reads; FIN
// registers the result once the output is free. The back-end sequencer works on one
// transaction at a time, and two-byte moves use its byte-wide memory once per byte.
// Reset clears the register pairs, empties the 2-entry decode queue and clears the result
// valid flag; the data memory is not cleared and holds whatever was written.
module ez80_indexed_move_execute
   import iem_pkg::*;
#(
   parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_type,
   input  logic [1:0]        req_page,
   input  logic [7:0]        req_opcode,
   input  logic signed [7:0] req_displacement,
   input  logic [2:0]        req_pair_index,
   input  logic [15:0]       req_value_in,
   input  logic [15:0]       req_mem_address,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_status,
   output logic [15:0]       rsp_read_value,
   output logic [15:0]       rsp_effective_address,
   output logic [2:0]        rsp_cycles
);

   logic        q_full;
   logic        push_valid;
   iem_uop_type push_uop;
   logic        q_pop;
   logic        q_valid;
   iem_uop_type q_head;

   iem_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_page         (req_page),
      .req_opcode       (req_opcode),
      .req_displacement (req_displacement),
      .req_pair_index   (req_pair_index),
      .req_value_in     (req_value_in),
      .req_mem_address  (req_mem_address),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_uop         (push_uop)
   );

   iem_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_uop   (push_uop),
      .q_full     (q_full),
      .q_pop      (q_pop),
      .q_valid    (q_valid),
      .q_head     (q_head)
   );

   iem_back #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_valid               (q_valid),
      .q_head                (q_head),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_read_value        (rsp_read_value),
      .rsp_effective_address (rsp_effective_address),
      .rsp_cycles            (rsp_cycles)
   );

endmodule

FILE: hw/rtl/iem_front.sv
module iem_front
   import iem_pkg::*;
(
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_type,
   input  logic [1:0]        req_page,
   input  logic [7:0]        req_opcode,
   input  logic signed [7:0] req_displacement,
   input  logic [2:0]        req_pair_index,
   input  logic [15:0]       req_value_in,
   input  logic [15:0]       req_mem_address,
   input  logic              q_full,
   output logic              push_valid,
   output iem_uop_type       push_uop
);

   logic [2:0] same_idx;
   logic [2:0] other_idx;
   logic [2:0] op_dst;

   assign req_stall  = q_full;
   assign push_valid = req_valid && !q_full;

   assign same_idx  = (req_page == PAGE_FD) ? PAIR_IY : PAIR_IX;
   assign other_idx = (req_page == PAGE_FD) ? PAIR_IX : PAIR_IY;
   assign op_dst    = {1'b0, req_opcode[5:4]};

   always_comb begin
      push_uop          = '0;
      push_uop.kind     = K_REFUSE;
      push_uop.cycles   = TICKS_NONE;
      push_uop.disp     = req_displacement;
      push_uop.value    = req_value_in;
      push_uop.maddr    = req_mem_address;
      push_uop.src_idx  = req_pair_index;
      push_uop.dst_idx  = req_pair_index;
      push_uop.base_idx = PAIR_HL;
      push_uop.use_d    = 1'b0;
      case (req_type)
         REQ_EXEC: begin
            push_uop.dst_idx = op_dst;
            push_uop.src_idx = op_dst;
            if (req_page == PAGE_ED) begin
               case (req_opcode)
                  OP_LEA_BC_IX, OP_LEA_DE_IX, OP_LEA_HL_IX: begin
                     push_uop.kind     = K_LEA;
                     push_uop.base_idx = PAIR_IX;
                     push_uop.use_d    = 1'b1;
                     push_uop.cycles   = TICKS_LEA;
                  end
                  OP_LEA_BC_IY, OP_LEA_DE_IY, OP_LEA_HL_IY: begin
                     push_uop.kind     = K_LEA;
                     push_uop.base_idx = PAIR_IY;
                     push_uop.use_d    = 1'b1;
                     push_uop.cycles   = TICKS_LEA;
                  end
                  OP_LD_BC_MEM, OP_LD_DE_MEM, OP_LD_HL_MEM: begin
                     push_uop.kind   = K_LOAD;
                     push_uop.cycles = TICKS_MOVE;
                  end
                  OP_ST_BC_MEM, OP_ST_DE_MEM, OP_ST_HL_MEM: begin
                     push_uop.kind   = K_STORE;
                     push_uop.cycles = TICKS_MOVE;
                  end
                  OP_LEA_IX_IX, OP_LEA_IY_IX, OP_LEA_IX_IY, OP_LEA_IY_IY: begin
                     push_uop.kind     = K_LEA;
                     push_uop.use_d    = 1'b1;
                     push_uop.cycles   = TICKS_LEA;
                     push_uop.base_idx =
                        (req_opcode == OP_LEA_IX_IX || req_opcode == OP_LEA_IY_IX) ?
                        PAIR_IX : PAIR_IY;
                     push_uop.dst_idx  =
                        (req_opcode == OP_LEA_IX_IX || req_opcode == OP_LEA_IX_IY) ?
                        PAIR_IX : PAIR_IY;
                  end
                  OP_PEA_IX, OP_PEA_IY: begin
                     push_uop.kind     = K_PEA;
                     push_uop.use_d    = 1'b1;
                     push_uop.cycles   = TICKS_LONG;
                     push_uop.src_idx  = PAIR_SP;
                     push_uop.base_idx = (req_opcode == OP_PEA_IX) ? PAIR_IX : PAIR_IY;
                  end
                  OP_LD_SAME, OP_LD_OTHER: begin
                     push_uop.kind    = K_LOAD;
                     push_uop.cycles  = TICKS_MOVE;
                     push_uop.dst_idx = (req_opcode == OP_LD_SAME) ? PAIR_IX : PAIR_IY;
                  end
                  OP_ST_SAME, OP_ST_OTHER: begin
                     push_uop.kind    = K_STORE;
                     push_uop.cycles  = TICKS_MOVE;
                     push_uop.src_idx = (req_opcode == OP_ST_SAME) ? PAIR_IX : PAIR_IY;
                  end
                  default: begin
                     push_uop.kind = K_REFUSE;
                  end
               endcase
            end else if (req_page == PAGE_DD || req_page == PAGE_FD) begin
               push_uop.base_idx = same_idx;
               push_uop.use_d    = 1'b1;
               case (req_opcode)
                  OP_LD_BC_MEM, OP_LD_DE_MEM, OP_LD_HL_MEM: begin
                     push_uop.kind   = K_LOAD;
                     push_uop.cycles = TICKS_MOVE;
                  end
                  OP_ST_BC_MEM, OP_ST_DE_MEM, OP_ST_HL_MEM: begin
                     push_uop.kind   = K_STORE;
                     push_uop.cycles = TICKS_MOVE;
                  end
                  OP_LD_SAME, OP_LD_OTHER: begin
                     push_uop.kind    = K_LOAD;
                     push_uop.cycles  = TICKS_LONG;
                     push_uop.dst_idx = (req_opcode == OP_LD_SAME) ? same_idx : other_idx;
                  end
                  OP_ST_SAME, OP_ST_OTHER: begin
                     push_uop.kind    = K_STORE;
                     push_uop.cycles  = TICKS_LONG;
                     push_uop.src_idx = (req_opcode == OP_ST_SAME) ? same_idx : other_idx;
                  end
                  default: begin
                     push_uop.kind = K_REFUSE;
                  end
               endcase
            end else begin
               push_uop.kind = K_REFUSE;
            end
         end
         REQ_SET_PAIR: begin
            if (req_pair_index <= PAIR_SP) push_uop.kind = K_SET;
         end
         REQ_WR_MEM: begin
            push_uop.kind = K_MEMWR;
         end
         REQ_RD_PAIR: begin
            if (req_pair_index <= PAIR_SP) push_uop.kind = K_RDPAIR;
         end
         REQ_RD_MEM: begin
            push_uop.kind = K_RDMEM;
         end
         default: begin
            push_uop.kind = K_REFUSE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/iem_queue.sv
module iem_queue
   import iem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  iem_uop_type push_uop,
   output logic        q_full,
   input  logic        q_pop,
   output logic        q_valid,
   output iem_uop_type q_head
);

   iem_uop_type                entry_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic                       do_pop;

   assign q_full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !do_pop) count_in = count_ff + 1'b1;
      else if (!push_valid && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) entry_ff[wr_ptr_ff] <= push_uop;
   end

endmodule

FILE: hw/rtl/iem_back.sv
module iem_back
   import iem_pkg::*;
#(
   parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  iem_uop_type q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [15:0] rsp_read_value,
   output logic [15:0] rsp_effective_address,
   output logic [2:0]  rsp_cycles
);

   localparam logic [15:0] MEM_MASK = 16'((32'd1 << MEM_ADDR_BITS) - 32'd1);
   localparam int          MEM_DEPTH = 1 << MEM_ADDR_BITS;

   iem_bk_state_type state_ff, state_in;

   logic [15:0] regs_ff [0:PAIR_COUNT-1];
   logic [7:0]  mem_ff [0:MEM_DEPTH-1];
   logic [7:0]  mem_rdata_ff;

   iem_uop_type cur_ff, cur_in;
   logic [15:0] a_ff, a_in;
   logic [15:0] addr2_ff, addr2_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  lo_ff, lo_in;
   logic        res_st_ff, res_st_in;
   logic [15:0] res_rv_ff, res_rv_in;
   logic [15:0] res_ea_ff, res_ea_in;
   logic [2:0]  res_cy_ff, res_cy_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff;
   logic [15:0] rsp_read_value_ff;
   logic [15:0] rsp_effective_address_ff;
   logic [2:0]  rsp_cycles_ff;

   logic [2:0]               rd_idx;
   logic [15:0]              rd_data;
   logic                     reg_we;
   logic [2:0]               reg_widx;
   logic [15:0]              reg_wdata;
   logic                     mem_we;
   logic [MEM_ADDR_BITS-1:0] mem_waddr;
   logic [7:0]               mem_wdata;
   logic [MEM_ADDR_BITS-1:0] mem_raddr;
   logic                     out_free;
   logic                     out_load;
   logic [15:0]              disp_ext;
   logic [15:0]              a_plus1;
   logic [15:0]              sp_m1;
   logic [15:0]              sp_m2;

   assign rd_data  = (rd_idx <= PAIR_SP) ? regs_ff[rd_idx] : 16'd0;
   assign disp_ext = {{8{q_head.disp[7]}}, q_head.disp};
   assign a_plus1  = a_ff + 16'd1;
   assign sp_m1    = rd_data - 16'd1;
   assign sp_m2    = rd_data - 16'd2;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) state_in = BK_EXEC;
         end
         BK_EXEC: begin
            case (cur_ff.kind)
               K_LOAD:         state_in = BK_LD1;
               K_STORE, K_PEA: state_in = BK_ST2;
               K_RDMEM:        state_in = BK_RDM;
               default:        state_in = BK_FIN;
            endcase
         end
         BK_LD1: state_in = BK_LD2;
         BK_LD2: state_in = BK_FIN;
         BK_ST2: state_in = BK_FIN;
         BK_RDM: state_in = BK_FIN;
         BK_FIN: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop     = 1'b0;
      rd_idx    = cur_ff.src_idx;
      reg_we    = 1'b0;
      reg_widx  = cur_ff.dst_idx;
      reg_wdata = 16'd0;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = 8'd0;
      mem_raddr = '0;
      out_load  = 1'b0;
      cur_in    = cur_ff;
      a_in      = a_ff;
      addr2_in  = addr2_ff;
      byte_in   = byte_ff;
      lo_in     = lo_ff;
      res_st_in = res_st_ff;
      res_rv_in = res_rv_ff;
      res_ea_in = res_ea_ff;
      res_cy_in = res_cy_ff;
      case (state_ff)
         BK_IDLE: begin
            // base pair is read while the transaction leaves the queue
            rd_idx = q_head.base_idx;
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               a_in   = rd_data + (q_head.use_d ? disp_ext : 16'd0);
            end
         end
         BK_EXEC: begin
            res_st_in = 1'b0;
            res_rv_in = 16'd0;
            res_ea_in = 16'd0;
            res_cy_in = cur_ff.cycles;
            case (cur_ff.kind)
               K_LEA: begin
                  reg_we    = 1'b1;
                  reg_wdata = a_ff;
                  res_rv_in = a_ff;
                  res_ea_in = a_ff;
               end
               K_LOAD: begin
                  mem_raddr = a_ff[MEM_ADDR_BITS-1:0];
                  addr2_in  = a_plus1;
                  res_ea_in = a_ff;
               end
               K_STORE: begin
                  mem_we    = 1'b1;
                  mem_waddr = a_ff[MEM_ADDR_BITS-1:0];
                  mem_wdata = rd_data[7:0];
                  byte_in   = rd_data[15:8];
                  addr2_in  = a_plus1;
                  res_rv_in = rd_data;
                  res_ea_in = a_ff;
               end
               K_PEA: begin
                  // high byte first at SP-1, low byte next cycle at SP-2
                  mem_we    = 1'b1;
                  mem_waddr = sp_m1[MEM_ADDR_BITS-1:0];
                  mem_wdata = a_ff[15:8];
                  byte_in   = a_ff[7:0];
                  addr2_in  = sp_m2;
                  reg_we    = 1'b1;
                  reg_widx  = PAIR_SP;
                  reg_wdata = sp_m2;
                  res_rv_in = a_ff;
                  res_ea_in = a_ff;
               end
               K_SET: begin
                  reg_we    = 1'b1;
                  reg_wdata = cur_ff.value;
                  res_rv_in = cur_ff.value;
               end
               K_RDPAIR: begin
                  res_rv_in = rd_data;
               end
               K_MEMWR: begin
                  mem_we    = 1'b1;
                  mem_waddr = cur_ff.maddr[MEM_ADDR_BITS-1:0];
                  mem_wdata = cur_ff.value[7:0];
                  res_rv_in = {8'd0, cur_ff.value[7:0]};
                  res_ea_in = cur_ff.maddr & MEM_MASK;
               end
               K_RDMEM: begin
                  mem_raddr = cur_ff.maddr[MEM_ADDR_BITS-1:0];
                  res_ea_in = cur_ff.maddr & MEM_MASK;
               end
               default: begin
                  res_st_in = 1'b1;
                  res_cy_in = TICKS_NONE;
               end
            endcase
         end
         BK_LD1: begin
            lo_in     = mem_rdata_ff;
            mem_raddr = addr2_ff[MEM_ADDR_BITS-1:0];
         end
         BK_LD2: begin
            reg_we    = 1'b1;
            reg_wdata = {mem_rdata_ff, lo_ff};
            res_rv_in = {mem_rdata_ff, lo_ff};
         end
         BK_ST2: begin
            mem_we    = 1'b1;
            mem_waddr = addr2_ff[MEM_ADDR_BITS-1:0];
            mem_wdata = byte_ff;
         end
         BK_RDM: begin
            res_rv_in = {8'd0, mem_rdata_ff};
         end
         BK_FIN: begin
            out_load = out_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PAIR_COUNT; i++) regs_ff[i] <= 16'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (reg_we) regs_ff[reg_widx] <= reg_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      a_ff      <= a_in;
      addr2_ff  <= addr2_in;
      byte_ff   <= byte_in;
      lo_ff     <= lo_in;
      res_st_ff <= res_st_in;
      res_rv_ff <= res_rv_in;
      res_ea_ff <= res_ea_in;
      res_cy_ff <= res_cy_in;
      if (out_load) begin
         rsp_status_ff            <= res_st_ff;
         rsp_read_value_ff        <= res_rv_ff;
         rsp_effective_address_ff <= res_ea_ff;
         rsp_cycles_ff            <= res_cy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem_ff[mem_raddr];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_read_value        = rsp_read_value_ff;
   assign rsp_effective_address = rsp_effective_address_ff;
   assign rsp_cycles            = rsp_cycles_ff;

endmodule
